@@ hw/rtl/hrhp_pkg.sv @@
// Package for the HTTP request header parser: types, match strings and helpers.
// Used by hrhp_front, hrhp_back and http_request_header_parser_top.
`default_nettype none
package hrhp_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int LEN_W       = LENGTH_BITS;

    // Match strings, lower case, right aligned (first char in the highest used byte)
    localparam logic [127:0] S_GET  = 128'("get");
    localparam logic [127:0] S_POST = 128'("post");
    localparam logic [127:0] S_VER  = 128'("http/1.1");
    localparam logic [127:0] S_CONN = 128'("connection:");
    localparam logic [127:0] S_CLEN = 128'("content-length:");
    localparam logic [127:0] S_HOST = 128'("host:");
    localparam logic [127:0] S_KA   = 128'("keep-alive");

    localparam logic [4:0] N_GET  = 5'd3;
    localparam logic [4:0] N_POST = 5'd4;
    localparam logic [4:0] N_VER  = 5'd8;
    localparam logic [4:0] N_CONN = 5'd11;
    localparam logic [4:0] N_CLEN = 5'd15;
    localparam logic [4:0] N_HOST = 5'd5;
    localparam logic [4:0] N_KA   = 5'd10;

    typedef enum logic [3:0] {
        PH_METHOD,
        PH_URL_SKIP,
        PH_URL,
        PH_VER_SKIP,
        PH_VERSION,
        PH_HDR_NAME,
        PH_HDR_SKIP,
        PH_HDR_VALUE,
        PH_HDR_OTHER,
        PH_BODY,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        HK_NONE,
        HK_CONN,
        HK_CLEN,
        HK_HOST
    } hdr_kind_t;

    typedef enum logic [1:0] {
        ST_BUSY,
        ST_DONE,
        ST_BAD
    } status_t;

    typedef enum logic [1:0] {
        BK_NONE,
        BK_URL,
        BK_HOST,
        BK_BODY
    } byte_kind_t;

    // Classified input byte handed from front to back
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] folded;
        logic       blank;
        logic       cr;
        logic       lf;
        logic       digit;
        logic       plus;
        logic       slash;
        logic       new_conn;
    } cls_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                r = c + 8'd32;
            end
            return r;
        end
    endfunction

    // Folded byte fc equals char pos of string s of length n
    function automatic logic str_match(input logic [127:0] s, input logic [4:0] n,
                                       input logic [4:0] pos, input logic [7:0] fc);
        logic [7:0] ch;
        logic [4:0] idx;
        begin
            ch  = 8'd0;
            idx = 5'd0;
            if (pos < n)
            begin
                idx = n - 5'd1 - pos;
                ch  = 8'(s >> {idx, 3'b000});
                return ch == fc;
            end
            return 1'b0;
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hrhp_front.sv @@
// Front end: accepts request bytes, classifies them, queues them for the back end.
// Depends on hrhp_pkg.
`default_nettype none
module hrhp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_new_conn,
    output logic               q_valid,
    input  wire logic          q_pop,
    output hrhp_pkg::cls_t     q_item
);

    hrhp_pkg::cls_t cls;
    hrhp_pkg::cls_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;

    // Classify the incoming byte
    always_comb
    begin
        cls.raw      = in_byte;
        cls.folded   = hrhp_pkg::fold(in_byte);
        cls.blank    = (in_byte == 8'h20) || (in_byte == 8'h09);
        cls.cr       = (in_byte == 8'h0D);
        cls.lf       = (in_byte == 8'h0A);
        cls.digit    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        cls.plus     = (in_byte == 8'h2B);
        cls.slash    = (in_byte == 8'h2F);
        cls.new_conn = in_new_conn;
    end

    // Two-entry queue
    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/hrhp_back.sv @@
// Back end: parser state machine, one classified byte per cycle unless the output stalls, output register.
// Depends on hrhp_pkg.
`default_nettype none
module hrhp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire hrhp_pkg::cls_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [47:0]         out_data,
    output logic [1:0]          out_user
);

    localparam int PW = hrhp_pkg::LEN_W + 4;

    hrhp_pkg::phase_t    phase_reg, phase_next, ph;
    hrhp_pkg::hdr_kind_t hk_reg, hk_next, hk;
    logic                cr_reg, cr_next, cr;
    logic [4:0]          pos_reg, pos_next, pos;
    logic [3:0]          cand_reg, cand_next, cand;
    logic                post_reg, post_next, post;
    logic                ka_reg, ka_next, ka;
    logic [hrhp_pkg::LEN_W-1:0] len_reg, len_next, len;
    logic [hrhp_pkg::LEN_W-1:0] rem_reg, rem_next, rem;

    logic [1:0]  kind;
    logic [1:0]  status;
    logic [PW-1:0] prod;
    logic [63:0] len64;
    logic        step;

    logic        ov_reg;
    logic [47:0] od_reg;
    logic [1:0]  ou_reg;

    assign step  = q_valid && (!ov_reg || out_ready);
    assign q_pop = step;

    // Next-state logic of the parser
    always_comb
    begin
        ph   = phase_reg; hk = hk_reg; cr = cr_reg; pos = pos_reg; cand = cand_reg;
        post = post_reg;  ka = ka_reg; len = len_reg; rem = rem_reg;
        kind = hrhp_pkg::BK_NONE;
        prod = '0;
        if (q_item.new_conn)
        begin
            ph = hrhp_pkg::PH_METHOD; hk = hrhp_pkg::HK_NONE; cr = 1'b0;
            pos = 5'd0; cand = 4'hF; post = 1'b0; ka = 1'b0; len = '0; rem = '0;
        end

        if (ph == hrhp_pkg::PH_ERROR || ph == hrhp_pkg::PH_DONE)
        begin
            // verdict holds
        end
        else if (ph == hrhp_pkg::PH_BODY)
        begin
            kind = hrhp_pkg::BK_BODY;
            if (rem != '0)
            begin
                rem = rem - 1'b1;
            end
            if (rem == '0)
            begin
                ph = hrhp_pkg::PH_DONE;
            end
        end
        else if (cr)
        begin
            cr = 1'b0;
            if (!q_item.lf)
            begin
                ph = hrhp_pkg::PH_ERROR;
            end
            else
            begin
                // line end
                unique case (ph) inside
                    hrhp_pkg::PH_VERSION:
                    begin
                        if (pos == hrhp_pkg::N_VER)
                        begin
                            ph = hrhp_pkg::PH_HDR_NAME; pos = 5'd0; cand = 4'h7;
                            hk = hrhp_pkg::HK_NONE;
                        end
                        else
                        begin
                            ph = hrhp_pkg::PH_ERROR;
                        end
                    end
                    hrhp_pkg::PH_HDR_NAME:
                    begin
                        if (pos == 5'd0)
                        begin
                            if (len != '0)
                            begin
                                rem = len;
                                ph  = hrhp_pkg::PH_BODY;
                            end
                            else
                            begin
                                ph = hrhp_pkg::PH_DONE;
                            end
                        end
                        else
                        begin
                            ph = hrhp_pkg::PH_HDR_NAME; pos = 5'd0; cand = 4'h7;
                            hk = hrhp_pkg::HK_NONE;
                        end
                    end
                    hrhp_pkg::PH_HDR_SKIP, hrhp_pkg::PH_HDR_VALUE:
                    begin
                        if (hk == hrhp_pkg::HK_CONN && cand[0] && pos == hrhp_pkg::N_KA)
                        begin
                            ka = 1'b1;
                        end
                        ph = hrhp_pkg::PH_HDR_NAME; pos = 5'd0; cand = 4'h7;
                        hk = hrhp_pkg::HK_NONE;
                    end
                    hrhp_pkg::PH_HDR_OTHER:
                    begin
                        ph = hrhp_pkg::PH_HDR_NAME; pos = 5'd0; cand = 4'h7;
                        hk = hrhp_pkg::HK_NONE;
                    end
                    default:
                    begin
                        ph = hrhp_pkg::PH_ERROR;
                    end
                endcase
            end
        end
        else if (q_item.cr)
        begin
            cr = 1'b1;
        end
        else if (q_item.lf)
        begin
            ph = hrhp_pkg::PH_ERROR;
        end
        else
        begin
            // ordinary byte
            unique case (ph) inside
                hrhp_pkg::PH_METHOD:
                begin
                    if (q_item.blank)
                    begin
                        if (cand[0] && pos == hrhp_pkg::N_GET)
                        begin
                            post = 1'b0; ph = hrhp_pkg::PH_URL_SKIP;
                        end
                        else if (cand[1] && pos == hrhp_pkg::N_POST)
                        begin
                            post = 1'b1; ph = hrhp_pkg::PH_URL_SKIP;
                        end
                        else
                        begin
                            ph = hrhp_pkg::PH_ERROR;
                        end
                    end
                    else
                    begin
                        if (!hrhp_pkg::str_match(hrhp_pkg::S_GET, hrhp_pkg::N_GET, pos,
                                                 q_item.folded))
                        begin
                            cand[0] = 1'b0;
                        end
                        if (!hrhp_pkg::str_match(hrhp_pkg::S_POST, hrhp_pkg::N_POST, pos,
                                                 q_item.folded))
                        begin
                            cand[1] = 1'b0;
                        end
                        if (cand[1:0] == 2'b00)
                        begin
                            ph = hrhp_pkg::PH_ERROR;
                        end
                        else if (pos < 5'd31)
                        begin
                            pos = pos + 5'd1;
                        end
                    end
                end
                hrhp_pkg::PH_URL_SKIP:
                begin
                    if (!q_item.blank)
                    begin
                        if (!q_item.slash)
                        begin
                            ph = hrhp_pkg::PH_ERROR;
                        end
                        else
                        begin
                            ph = hrhp_pkg::PH_URL; kind = hrhp_pkg::BK_URL;
                        end
                    end
                end
                hrhp_pkg::PH_URL:
                begin
                    if (q_item.blank)
                    begin
                        ph = hrhp_pkg::PH_VER_SKIP;
                    end
                    else
                    begin
                        kind = hrhp_pkg::BK_URL;
                    end
                end
                hrhp_pkg::PH_VER_SKIP, hrhp_pkg::PH_VERSION:
                begin
                    if (!(ph == hrhp_pkg::PH_VER_SKIP && q_item.blank))
                    begin
                        if (ph == hrhp_pkg::PH_VER_SKIP)
                        begin
                            pos = 5'd0;
                        end
                        ph = hrhp_pkg::PH_VERSION;
                        if (hrhp_pkg::str_match(hrhp_pkg::S_VER, hrhp_pkg::N_VER, pos,
                                                q_item.folded))
                        begin
                            if (pos < 5'd31)
                            begin
                                pos = pos + 5'd1;
                            end
                        end
                        else
                        begin
                            ph = hrhp_pkg::PH_ERROR;
                        end
                    end
                end
                hrhp_pkg::PH_HDR_NAME:
                begin
                    if (!hrhp_pkg::str_match(hrhp_pkg::S_CONN, hrhp_pkg::N_CONN, pos,
                                             q_item.folded))
                    begin
                        cand[0] = 1'b0;
                    end
                    if (!hrhp_pkg::str_match(hrhp_pkg::S_CLEN, hrhp_pkg::N_CLEN, pos,
                                             q_item.folded))
                    begin
                        cand[1] = 1'b0;
                    end
                    if (!hrhp_pkg::str_match(hrhp_pkg::S_HOST, hrhp_pkg::N_HOST, pos,
                                             q_item.folded))
                    begin
                        cand[2] = 1'b0;
                    end
                    if (pos < 5'd31)
                    begin
                        pos = pos + 5'd1;
                    end
                    if (cand[0] && pos == hrhp_pkg::N_CONN)
                    begin
                        hk = hrhp_pkg::HK_CONN;
                    end
                    else if (cand[1] && pos == hrhp_pkg::N_CLEN)
                    begin
                        hk = hrhp_pkg::HK_CLEN; len = '0;
                    end
                    else if (cand[2] && pos == hrhp_pkg::N_HOST)
                    begin
                        hk = hrhp_pkg::HK_HOST;
                    end
                    if (hk != hrhp_pkg::HK_NONE)
                    begin
                        ph = hrhp_pkg::PH_HDR_SKIP; pos = 5'd0; cand = 4'h1;
                    end
                    else if (cand[2:0] == 3'b000)
                    begin
                        ph = hrhp_pkg::PH_HDR_OTHER;
                    end
                end
                hrhp_pkg::PH_HDR_SKIP, hrhp_pkg::PH_HDR_VALUE:
                begin
                    if (!(ph == hrhp_pkg::PH_HDR_SKIP && q_item.blank))
                    begin
                        ph = hrhp_pkg::PH_HDR_VALUE;
                        // header value byte
                        unique case (hk)
                            hrhp_pkg::HK_HOST:
                            begin
                                kind = hrhp_pkg::BK_HOST;
                            end
                            hrhp_pkg::HK_CONN:
                            begin
                                if (cand[0] && hrhp_pkg::str_match(hrhp_pkg::S_KA,
                                        hrhp_pkg::N_KA, pos, q_item.folded))
                                begin
                                    if (pos < 5'd31)
                                    begin
                                        pos = pos + 5'd1;
                                    end
                                end
                                else
                                begin
                                    cand = 4'h0;
                                end
                            end
                            hrhp_pkg::HK_CLEN:
                            begin
                                if (cand[0])
                                begin
                                    if (q_item.digit)
                                    begin
                                        prod = ({4'd0, len} << 3) + ({4'd0, len} << 1)
                                             + PW'(q_item.raw[3:0]);
                                        if (prod[PW-1 -: 4] != 4'd0)
                                        begin
                                            len = '1;
                                        end
                                        else
                                        begin
                                            len = prod[hrhp_pkg::LEN_W-1:0];
                                        end
                                        pos = 5'd1;
                                    end
                                    else if (q_item.plus && pos == 5'd0)
                                    begin
                                        pos = 5'd1;
                                    end
                                    else
                                    begin
                                        cand = 4'h0;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end

        phase_next = ph; hk_next = hk; cr_next = cr; pos_next = pos; cand_next = cand;
        post_next = post; ka_next = ka; len_next = len; rem_next = rem;
    end

    // Result fields
    always_comb
    begin
        len64 = 64'(len_next);
        if (phase_next == hrhp_pkg::PH_ERROR)
        begin
            status = hrhp_pkg::ST_BAD;
        end
        else if (phase_next == hrhp_pkg::PH_DONE)
        begin
            status = hrhp_pkg::ST_DONE;
        end
        else
        begin
            status = hrhp_pkg::ST_BUSY;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hrhp_pkg::PH_METHOD;
            hk_reg    <= hrhp_pkg::HK_NONE;
            cr_reg    <= 1'b0;
            pos_reg   <= 5'd0;
            cand_reg  <= 4'hF;
            post_reg  <= 1'b0;
            ka_reg    <= 1'b0;
            len_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hk_reg    <= hk_next;
            cr_reg    <= cr_next;
            pos_reg   <= pos_next;
            cand_reg  <= cand_next;
            post_reg  <= post_next;
            ka_reg    <= ka_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (step)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            od_reg[1:0]   <= status;
            od_reg[2]     <= post_next;
            od_reg[3]     <= ka_next;
            od_reg[35:4]  <= (len64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len64[31:0];
            od_reg[43:36] <= (status == hrhp_pkg::ST_BAD || kind == hrhp_pkg::BK_NONE)
                             ? 8'd0 : q_item.raw;
            od_reg[47:44] <= 4'd0;
            ou_reg        <= (status == hrhp_pkg::ST_BAD) ? hrhp_pkg::BK_NONE : kind;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_user  = ou_reg;

endmodule
`default_nettype wire

@@ hw/rtl/http_request_header_parser_top.sv @@
// Top level of the HTTP request header parser: front queue plus parser back end.
// Depends on hrhp_pkg, hrhp_front, hrhp_back.
//
//  Group    | Dir | Payload
//  s_axis_* | in  | tdata[7:0] data_byte; tuser[0] new_connection
//  m_axis_* | out | tdata: status, method_post, keep_alive, body_length, byte_out;
//           |     | tuser[1:0] byte_kind
//
// One request byte per cycle sustained while the output is ready; a byte passes
// from the two-entry queue through the parser step into the output register.
// Reset clears the queue, parser state and output valid. Output stalls hold
// bytes in the queue, fill it and then drop s_axis_tready.
`default_nettype none
module http_request_header_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] new_connection
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [1:0] status, [2] method_post,
                                             // [3] keep_alive, [35:4] body_length,
                                             // [43:36] byte_out, [47:44] zero
    output logic [1:0]       m_axis_tuser    // [1:0] byte_kind
);

    logic           q_valid;
    logic           q_pop;
    hrhp_pkg::cls_t q_item;

    hrhp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_new_conn (s_axis_tuser[0]),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    hrhp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule
`default_nettype wire

@@ tb/tb_http_request_header_parser_top.sv @@
// Testbench for http_request_header_parser_top: drives request byte streams and checks
// every parser result against a behavioral parser kept in this file.
// Depends on hrhp_pkg and the RTL of the parser.
`default_nettype none
module tb_http_request_header_parser_top;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser;   // [0] new_connection
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [1:0] status, [2] method_post, [3] keep_alive,
                                 // [35:4] body_length, [43:36] byte_out
    logic [1:0]  m_axis_tuser;   // [1:0] byte_kind

    http_request_header_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    typedef struct packed {
        hrhp_pkg::status_t    status;
        logic                 post;
        logic                 keep;
        logic [31:0]          blen;
        logic [7:0]           bout;
        hrhp_pkg::byte_kind_t kind;
    } parse_res_t;

    // Parser model state
    hrhp_pkg::phase_t    ph;
    logic                crp;
    int unsigned         mpos;
    logic [3:0]          cand;
    hrhp_pkg::hdr_kind_t hk;
    logic                postf;
    logic                kaf;
    logic [31:0]         clen;
    logic [31:0]         body_left;

    parse_res_t results_q[$];
    int         err_count;
    int         req_sent;
    logic       hold_off;
    logic       hold_armed;

    string s_get_str  = "get";
    string s_post_str = "post";
    string s_ver_str  = "http/1.1";
    string s_conn_str = "connection:";
    string s_clen_str = "content-length:";
    string s_host_str = "host:";
    string s_ka_str   = "keep-alive";

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic hit(input logic [7:0] c, input string s, input int unsigned p);
        return p < s.len() && lower(c) == s[p];
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction

    function automatic void clear_parser();
        ph = hrhp_pkg::PH_METHOD;
        crp = 1'b0;
        mpos = 0;
        cand = 4'hF;
        hk = hrhp_pkg::HK_NONE;
        postf = 1'b0;
        kaf = 1'b0;
        clen = '0;
        body_left = '0;
    endfunction

    function automatic void bump();
        if (mpos < 31)
        begin
            mpos++;
        end
    endfunction

    function automatic void new_header_line();
        ph = hrhp_pkg::PH_HDR_NAME;
        mpos = 0;
        cand = 4'h7;
        hk = hrhp_pkg::HK_NONE;
    endfunction

    function automatic void header_value(input logic [7:0] c,
                                         output hrhp_pkg::byte_kind_t k);
        logic [32:0] nxt;
        k = hrhp_pkg::BK_NONE;
        if (hk == hrhp_pkg::HK_HOST)
        begin
            k = hrhp_pkg::BK_HOST;
        end
        else if (hk == hrhp_pkg::HK_CONN)
        begin
            if (cand[0] && hit(c, s_ka_str, mpos))
            begin
                bump();
            end
            else
            begin
                cand = '0;
            end
        end
        else if (hk == hrhp_pkg::HK_CLEN && cand[0])
        begin
            if (c >= "0" && c <= "9")
            begin
                nxt = {1'b0, clen} * 33'd10 + 33'(c - "0");
                if ({1'b0, clen} > 33'h0FFFFFFFF / 10 || nxt > 33'h0FFFFFFFF)
                begin
                    clen = '1;
                end
                else
                begin
                    clen = nxt[31:0];
                end
                mpos = 1;
            end
            else if (c == "+" && mpos == 0)
            begin
                mpos = 1;
            end
            else
            begin
                cand = '0;
            end
        end
    endfunction

    function automatic void line_byte(input logic [7:0] c, output hrhp_pkg::byte_kind_t k);
        k = hrhp_pkg::BK_NONE;
        case (ph) inside
            hrhp_pkg::PH_METHOD:
            begin
                if (blank(c))
                begin
                    if (cand[0] && mpos == 3)
                    begin
                        postf = 1'b0;
                        ph = hrhp_pkg::PH_URL_SKIP;
                    end
                    else if (cand[1] && mpos == 4)
                    begin
                        postf = 1'b1;
                        ph = hrhp_pkg::PH_URL_SKIP;
                    end
                    else
                    begin
                        ph = hrhp_pkg::PH_ERROR;
                    end
                end
                else
                begin
                    if (!hit(c, s_get_str, mpos)) cand[0] = 1'b0;
                    if (!hit(c, s_post_str, mpos)) cand[1] = 1'b0;
                    if (cand[1:0] == 2'b00) ph = hrhp_pkg::PH_ERROR;
                    else bump();
                end
            end
            hrhp_pkg::PH_URL_SKIP:
            begin
                if (!blank(c))
                begin
                    if (c != "/") ph = hrhp_pkg::PH_ERROR;
                    else
                    begin
                        ph = hrhp_pkg::PH_URL;
                        k = hrhp_pkg::BK_URL;
                    end
                end
            end
            hrhp_pkg::PH_URL:
            begin
                if (blank(c)) ph = hrhp_pkg::PH_VER_SKIP;
                else k = hrhp_pkg::BK_URL;
            end
            hrhp_pkg::PH_VER_SKIP, hrhp_pkg::PH_VERSION:
            begin
                if (!(ph == hrhp_pkg::PH_VER_SKIP && blank(c)))
                begin
                    if (ph == hrhp_pkg::PH_VER_SKIP)
                    begin
                        ph = hrhp_pkg::PH_VERSION;
                        mpos = 0;
                    end
                    if (hit(c, s_ver_str, mpos)) bump();
                    else ph = hrhp_pkg::PH_ERROR;
                end
            end
            hrhp_pkg::PH_HDR_NAME:
            begin
                if (!hit(c, s_conn_str, mpos)) cand[0] = 1'b0;
                if (!hit(c, s_clen_str, mpos)) cand[1] = 1'b0;
                if (!hit(c, s_host_str, mpos)) cand[2] = 1'b0;
                bump();
                if (cand[0] && mpos == 11) hk = hrhp_pkg::HK_CONN;
                else if (cand[1] && mpos == 15) hk = hrhp_pkg::HK_CLEN;
                else if (cand[2] && mpos == 5) hk = hrhp_pkg::HK_HOST;
                if (hk != hrhp_pkg::HK_NONE)
                begin
                    if (hk == hrhp_pkg::HK_CLEN) clen = '0;
                    ph = hrhp_pkg::PH_HDR_SKIP;
                    mpos = 0;
                    cand = 4'h1;
                end
                else if (cand[2:0] == 3'b000)
                begin
                    ph = hrhp_pkg::PH_HDR_OTHER;
                end
            end
            hrhp_pkg::PH_HDR_SKIP:
            begin
                if (!blank(c))
                begin
                    ph = hrhp_pkg::PH_HDR_VALUE;
                    header_value(c, k);
                end
            end
            hrhp_pkg::PH_HDR_VALUE: header_value(c, k);
            default: ;
        endcase
    endfunction

    function automatic void end_of_line();
        case (ph) inside
            hrhp_pkg::PH_VERSION:
            begin
                if (mpos == 8) new_header_line();
                else ph = hrhp_pkg::PH_ERROR;
            end
            hrhp_pkg::PH_HDR_NAME:
            begin
                if (mpos == 0)
                begin
                    if (clen != 0)
                    begin
                        body_left = clen;
                        ph = hrhp_pkg::PH_BODY;
                    end
                    else
                    begin
                        ph = hrhp_pkg::PH_DONE;
                    end
                end
                else
                begin
                    new_header_line();
                end
            end
            hrhp_pkg::PH_HDR_SKIP, hrhp_pkg::PH_HDR_VALUE:
            begin
                if (hk == hrhp_pkg::HK_CONN && cand[0] && mpos == 10) kaf = 1'b1;
                new_header_line();
            end
            hrhp_pkg::PH_HDR_OTHER: new_header_line();
            default: ph = hrhp_pkg::PH_ERROR;
        endcase
    endfunction

    // Advance the model by one request byte and return the parser result
    function automatic parse_res_t predict_parse(input logic [7:0] c, input logic nc);
        parse_res_t r;
        hrhp_pkg::byte_kind_t k;
        k = hrhp_pkg::BK_NONE;
        if (nc) clear_parser();
        if (ph == hrhp_pkg::PH_ERROR || ph == hrhp_pkg::PH_DONE)
        begin
        end
        else if (ph == hrhp_pkg::PH_BODY)
        begin
            k = hrhp_pkg::BK_BODY;
            if (body_left > 0) body_left--;
            if (body_left == 0) ph = hrhp_pkg::PH_DONE;
        end
        else if (crp)
        begin
            crp = 1'b0;
            if (c == 8'h0A) end_of_line();
            else ph = hrhp_pkg::PH_ERROR;
        end
        else if (c == 8'h0D) crp = 1'b1;
        else if (c == 8'h0A) ph = hrhp_pkg::PH_ERROR;
        else line_byte(c, k);
        r.status = (ph == hrhp_pkg::PH_ERROR) ? hrhp_pkg::ST_BAD
                 : (ph == hrhp_pkg::PH_DONE) ? hrhp_pkg::ST_DONE : hrhp_pkg::ST_BUSY;
        if (r.status == hrhp_pkg::ST_BAD) k = hrhp_pkg::BK_NONE;
        r.post = postf;
        r.keep = kaf;
        r.blen = clen;
        r.bout = (k != hrhp_pkg::BK_NONE) ? c : 8'h00;
        r.kind = k;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Stream bytes: random gaps between bytes
    task automatic send_byte(input logic [7:0] c, input logic nc);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
            : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= nc;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        results_q.push_back(predict_parse(c, nc));
        req_sent++;
    endtask

    task automatic send_text(input string s, input logic first_nc);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], first_nc && i == 0);
        end
    endtask

    function automatic string mixcase(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
        begin
            if ($urandom_range(0, 1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
        end
        return r;
    endfunction

    function automatic string rand_token(input int n);
        string r;
        r = "";
        for (int i = 0; i < n; i++)
        begin
            r = {r, string'(byte'($urandom_range(33, 126)))};
        end
        return r;
    endfunction

    function automatic string blanks();
        return $urandom_range(0, 3) == 0 ? " \t " : " ";
    endfunction

    // Well-formed request with random content, sometimes broken
    task automatic send_request();
        string s;
        string body;
        int blen;
        logic post;
        post = $urandom_range(0, 1);
        blen = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        s = {mixcase(post ? "post" : "get"), blanks(), "/", rand_token($urandom_range(0, 6)),
             blanks(), mixcase("http/1.1"), "\r\n"};
        if ($urandom_range(0, 1)) s = {s, mixcase("host:"), blanks(),
                                       rand_token($urandom_range(1, 6)), "\r\n"};
        if ($urandom_range(0, 1)) s = {s, mixcase("connection:"), " ",
                                       $urandom_range(0, 3) ? mixcase("keep-alive") : "close",
                                       "\r\n"};
        if ($urandom_range(0, 2) == 0) s = {s, "X-", rand_token(3), ": v\r\n"};
        if (blen > 0) s = {s, mixcase("content-length:"), blanks(), $sformatf("%0d", blen),
                           "\r\n"};
        s = {s, "\r\n"};
        body = "";
        for (int i = 0; i < blen; i++) body = {body, string'(byte'($urandom_range(0, 255)))};
        s = {s, body, "tail"};
        // Corrupt one byte now and then
        if ($urandom_range(0, 4) == 0)
        begin
            s[$urandom_range(0, s.len() - 1)] = byte'($urandom_range(0, 255));
        end
        send_text(s, 1'b1);
    endtask

    // Results: compare each against the oldest expectation
    always @(posedge clk)
    begin
        parse_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_q.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 0);
            end
            else
            begin
                want = results_q.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    report_mismatch("status", m_axis_tdata[1:0], want.status);
                if (m_axis_tdata[2] != want.post)
                    report_mismatch("method_post", m_axis_tdata[2], want.post);
                if (m_axis_tdata[3] != want.keep)
                    report_mismatch("keep_alive", m_axis_tdata[3], want.keep);
                if (m_axis_tdata[35:4] != want.blen)
                    report_mismatch("body_length", m_axis_tdata[35:4], want.blen);
                if (m_axis_tdata[43:36] != want.bout)
                    report_mismatch("byte_out", m_axis_tdata[43:36], want.bout);
                if (m_axis_tuser != want.kind)
                    report_mismatch("byte_kind", m_axis_tuser, want.kind);
            end
        end
    end

    // Receiver: random stalls, one long hold-off mid run
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (req_sent > 300 && req_sent < 600)
                m_axis_tready <= 1'b1;
            else if ($urandom_range(0, 19) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(5, 25)) @(posedge clk);
            end
            else
                m_axis_tready <= $urandom_range(0, 3) != 0;
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    typedef struct {
        logic [7:0]           c;
        logic                 nc;
        logic                 fixed;
        hrhp_pkg::status_t    status;
        hrhp_pkg::byte_kind_t kind;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{8'h0A, 1'b1, 1'b1, hrhp_pkg::ST_BAD,  hrhp_pkg::BK_NONE},   // bare LF on first byte
        '{8'hFF, 1'b0, 1'b1, hrhp_pkg::ST_BAD,  hrhp_pkg::BK_NONE},   // verdict sticks
        '{8'h00, 1'b1, 1'b0, hrhp_pkg::ST_BUSY, hrhp_pkg::BK_NONE},   // zero byte
        '{"P",   1'b1, 1'b1, hrhp_pkg::ST_BUSY, hrhp_pkg::BK_NONE},
        '{"g",   1'b1, 1'b1, hrhp_pkg::ST_BUSY, hrhp_pkg::BK_NONE},
        '{"E",   1'b0, 1'b1, hrhp_pkg::ST_BUSY, hrhp_pkg::BK_NONE},
        '{"t",   1'b0, 1'b1, hrhp_pkg::ST_BUSY, hrhp_pkg::BK_NONE},
        '{" ",   1'b0, 1'b1, hrhp_pkg::ST_BUSY, hrhp_pkg::BK_NONE},
        '{"x",   1'b0, 1'b1, hrhp_pkg::ST_BAD,  hrhp_pkg::BK_NONE},   // URL without slash
        '{"G",   1'b1, 1'b0, hrhp_pkg::ST_BUSY, hrhp_pkg::BK_NONE},
        '{8'h0D, 1'b0, 1'b0, hrhp_pkg::ST_BUSY, hrhp_pkg::BK_NONE},
        '{"a",   1'b0, 1'b1, hrhp_pkg::ST_BAD,  hrhp_pkg::BK_NONE},   // bare CR
        '{"X",   1'b1, 1'b1, hrhp_pkg::ST_BAD,  hrhp_pkg::BK_NONE},   // early rejection
        '{8'h80, 1'b1, 1'b1, hrhp_pkg::ST_BAD,  hrhp_pkg::BK_NONE}
    };

    string dir_texts[] = '{
        "GET / HTTP/1.1\r\n\r\nzz",
        "post\t/a%7F  Http/1.1\r\nHost:  h.x\r\nConnection: keep-alive\r\n\r\n",
        "GET /x HTTP/1.1 \r\n",
        "GET /x HTTP/1.\r\n",
        "GET / HTTP/1.1\r\nContent-length: +99999999999\r\nContent-Length:3\r\n\r\nabcd",
        "GET / HTTP/1.1\r\nContent-length: -5\r\n Host: q\r\nConnection: keep-alivex\r\n\r\n",
        "GET / HTTP/1.1\r\nConnection: Keep-Alive\r\nConnection: close\r\nX\r\n\r\n",
        "POST / HTTP/1.1\r\nContent-length: 2\r\n\r\n\r\n"
    };

    initial
    begin
        parse_res_t r;
        err_count = 0;
        req_sent = 0;
        hold_off = 1'b0;
        hold_armed = 1'b1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        clear_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: fixed rows check status and kind at once
        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].c, dir_rows[i].nc);
            r = results_q[$];
            if (dir_rows[i].fixed &&
                (r.status != dir_rows[i].status || r.kind != dir_rows[i].kind))
                report_mismatch("directed row", i, {r.status, r.kind});
        end
        foreach (dir_texts[i]) send_text(dir_texts[i], 1'b1);

        // Random part: mostly requests, some noise
        while (req_sent < 950)
        begin
            if (req_sent > 500 && hold_armed)
            begin
                hold_off = 1'b1;
                hold_armed = 1'b0;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte($urandom_range(0, 255), $urandom_range(0, 7) == 0);
            end
            else
            begin
                send_request();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (results_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
